// ===== sv/wws_pkg.sv =====
package wws_pkg;

  // delimiter characters
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_PERIOD  = 8'h2E;
  localparam logic [7:0] CH_COMMA   = 8'h2C;

  // counter ceiling
  localparam logic [15:0] SAT16 = 16'hFFFF;

  // configuration register indexes
  localparam logic [1:0] CFG_KEY_LOW    = 2'd0;
  localparam logic [1:0] CFG_KEY_HIGH   = 2'd1;
  localparam logic [1:0] CFG_KEY_LENGTH = 2'd2;

  // report kinds
  localparam logic REPORT_MATCH = 1'b0;
  localparam logic REPORT_COUNT = 1'b1;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // one classified byte that causes at least one result
  typedef struct packed {
    logic        has_match;
    logic        has_count;
    logic [15:0] line;
    logic [15:0] column;
    logic [15:0] total;
  } event_t;

  function automatic logic [15:0] inc_sat16(input logic [15:0] v);
    return (v == SAT16) ? v : v + 16'd1;
  endfunction

endpackage

// ===== sv/wws_front.sv =====
module wws_front #(
  parameter int MAX_KEY_CHARS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic [1:0]      cfg_index,
  input  logic [63:0]     cfg_data,
  input  logic            accept,
  input  logic [7:0]      text_byte,
  input  logic            end_of_text,
  output logic            ev_push,
  output wws_pkg::event_t ev_data
);
  import wws_pkg::*;

  localparam logic [4:0] MAX_LEN = 5'(MAX_KEY_CHARS);
  localparam logic [4:0] LEN_CAP = 5'(MAX_KEY_CHARS + 1);

  logic [63:0] key_low;
  logic [63:0] key_high;
  logic [4:0]  key_length;

  logic [4:0]  token_length;
  logic        token_still_equal;
  logic [15:0] current_line;
  logic [15:0] current_column;
  logic [15:0] token_start_column;
  logic [15:0] matches_seen;

  logic [4:0]  token_length_next;
  logic        token_still_equal_next;
  logic [15:0] current_line_next;
  logic [15:0] current_column_next;
  logic [15:0] token_start_column_next;
  logic [15:0] matches_seen_next;

  logic [127:0] key_all;
  logic [7:0]   key_char;
  logic         is_delim;
  logic         key_len_ok;
  logic         in_key;
  logic [4:0]   grown_length;
  logic         grown_equal;
  logic [15:0]  start_col;
  logic         hit;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low    <= '0;
      key_high   <= '0;
      key_length <= 5'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_KEY_LOW:    key_low    <= cfg_data;
        CFG_KEY_HIGH:   key_high   <= cfg_data;
        CFG_KEY_LENGTH: key_length <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign key_all    = {key_high, key_low};
  assign key_char   = key_all[{token_length[3:0], 3'b000} +: 8];
  assign key_len_ok = (key_length != 5'd0) && (key_length <= MAX_LEN);
  assign is_delim   = (text_byte == CH_SPACE) || (text_byte == CH_NEWLINE) ||
                      (text_byte == CH_PERIOD) || (text_byte == CH_COMMA);

  // token growth on an ordinary character
  assign in_key       = (token_length < key_length) && (token_length < MAX_LEN);
  assign grown_equal  = token_still_equal && in_key && (key_char == text_byte);
  assign grown_length = (token_length < LEN_CAP) ? token_length + 5'd1 : token_length;
  assign start_col    = (token_length == 5'd0) ? current_column : token_start_column;

  // classify the byte and update the text state
  always_comb begin
    token_length_next       = token_length;
    token_still_equal_next  = token_still_equal;
    current_line_next       = current_line;
    current_column_next     = current_column;
    token_start_column_next = token_start_column;
    hit                     = 1'b0;
    ev_data.line            = current_line;
    ev_data.column          = token_start_column;

    if (is_delim) begin
      hit = (token_length != 5'd0) && token_still_equal && key_len_ok &&
            (token_length == key_length);
      token_length_next      = 5'd0;
      token_still_equal_next = 1'b1;
      if (text_byte == CH_NEWLINE) begin
        current_line_next   = inc_sat16(current_line);
        current_column_next = '0;
      end else begin
        current_column_next = inc_sat16(current_column);
      end
    end else begin
      token_start_column_next = start_col;
      token_length_next       = grown_length;
      token_still_equal_next  = grown_equal;
      current_column_next     = inc_sat16(current_column);
      ev_data.column          = start_col;
      if (end_of_text) begin
        hit = grown_equal && key_len_ok && (grown_length == key_length);
      end
    end

    matches_seen_next = hit ? inc_sat16(matches_seen) : matches_seen;

    ev_data.has_match = hit;
    ev_data.has_count = end_of_text;
    ev_data.total     = matches_seen_next;
  end

  assign ev_push = accept && (hit || end_of_text);

  // text state, cleared after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      token_length       <= '0;
      token_still_equal  <= 1'b1;
      current_line       <= 16'd1;
      current_column     <= '0;
      token_start_column <= '0;
      matches_seen       <= '0;
    end else if (accept) begin
      if (end_of_text) begin
        token_length       <= '0;
        token_still_equal  <= 1'b1;
        current_line       <= 16'd1;
        current_column     <= '0;
        token_start_column <= '0;
        matches_seen       <= '0;
      end else begin
        token_length       <= token_length_next;
        token_still_equal  <= token_still_equal_next;
        current_line       <= current_line_next;
        current_column     <= current_column_next;
        token_start_column <= token_start_column_next;
        matches_seen       <= matches_seen_next;
      end
    end
  end

endmodule

// ===== sv/wws_queue.sv =====
module wws_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  wws_pkg::event_t wr_data,
  output logic            q_full,
  input  logic            rd_en,
  output wws_pkg::event_t rd_data,
  output logic            q_empty
);
  import wws_pkg::*;

  event_t                 mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   do_wr;
  logic                   do_rd;

  assign q_full  = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/wws_back.sv =====
module wws_back (
  input  logic            clk,
  input  logic            rst,
  input  wws_pkg::event_t ev_data,
  input  logic            ev_empty,
  output logic            ev_pop,
  output logic            empty,
  input  logic            pop,
  output logic            report_kind,
  output logic [15:0]     line_number,
  output logic [15:0]     column_number,
  output logic [15:0]     match_total,
  output logic            final_report
);
  import wws_pkg::*;

  logic        out_valid;
  logic        pend_count;
  logic [15:0] pend_total;
  logic        out_free;

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;
  assign ev_pop   = out_free && !pend_count && !ev_empty;

  // control: output stage valid and the count report still owed
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_count <= 1'b0;
    end else if (out_free) begin
      if (pend_count) begin
        out_valid  <= 1'b1;
        pend_count <= 1'b0;
      end else if (!ev_empty) begin
        out_valid  <= 1'b1;
        pend_count <= ev_data.has_match && ev_data.has_count;
      end else begin
        out_valid  <= 1'b0;
      end
    end
  end

  // result payload, match report first then count report
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend_count || (!ev_empty && !ev_data.has_match)) begin
        report_kind   <= REPORT_COUNT;
        line_number   <= '0;
        column_number <= '0;
        match_total   <= pend_count ? pend_total : ev_data.total;
        final_report  <= 1'b1;
      end else if (!ev_empty) begin
        report_kind   <= REPORT_MATCH;
        line_number   <= ev_data.line;
        column_number <= ev_data.column;
        match_total   <= ev_data.total;
        final_report  <= 1'b0;
      end
      if (!pend_count && !ev_empty) begin
        pend_total <= ev_data.total;
      end
    end
  end

endmodule

// ===== sv/whole_word_search_line_column_top.sv =====
// Whole-word keyword search over a byte stream. Space, newline, period and
// comma end a token; a token equal to the keyword (key_length characters,
// character 0 in the low byte of key_low) gives a match report with its
// 1-based line and 0-based start column, and the byte flagged end_of_text
// closes the last token and gives a count report with final_report set,
// after which line, column and match counts start over. The input side takes
// one byte per clock: the front classifies each byte in the cycle it is
// accepted and sends bytes that cause results into a four-entry event queue.
// The back turns each event into one or two results at one result per clock,
// so the long-run rate is one byte per cycle unless results come faster than
// the result side drains them; full rises only when the event queue fills.
// Configuration writes (index 0 low key bytes, 1 high key bytes, 2 length)
// are always ready and are meant to be made while the block is idle.
module whole_word_search_line_column_top #(
  parameter int MAX_KEY_CHARS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  output logic        empty,
  input  logic        pop,
  output logic        report_kind,
  output logic [15:0] line_number,
  output logic [15:0] column_number,
  output logic [15:0] match_total,
  output logic        final_report
);
  import wws_pkg::*;

  logic   accept;
  logic   ev_push;
  event_t ev_in;
  event_t ev_out;
  logic   ev_empty;
  logic   ev_pop;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  // front: configuration and byte classification
  wws_front #(
    .MAX_KEY_CHARS (MAX_KEY_CHARS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .ev_push     (ev_push),
    .ev_data     (ev_in)
  );

  // event queue between front and back
  wws_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (ev_push),
    .wr_data (ev_in),
    .q_full  (full),
    .rd_en   (ev_pop),
    .rd_data (ev_out),
    .q_empty (ev_empty)
  );

  // back: result expansion and output stage
  wws_back u_back (
    .clk           (clk),
    .rst           (rst),
    .ev_data       (ev_out),
    .ev_empty      (ev_empty),
    .ev_pop        (ev_pop),
    .empty         (empty),
    .pop           (pop),
    .report_kind   (report_kind),
    .line_number   (line_number),
    .column_number (column_number),
    .match_total   (match_total),
    .final_report  (final_report)
  );

endmodule

// ===== bench/tb_whole_word_search_line_column_top.sv =====
`timescale 1ns / 1ps

module tb_whole_word_search_line_column_top;
  import wws_pkg::*;

  localparam int MAX_KEY       = 16;
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLDOFF_LEN   = 300;

  // one expected result
  typedef struct packed {
    logic        kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [15:0] total;
    logic        last;
  } report_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        push;
  logic        full;
  logic [7:0]  text_byte;
  logic        end_of_text;
  logic        empty;
  logic        pop = 1'b0;
  logic        report_kind;
  logic [15:0] line_number;
  logic [15:0] column_number;
  logic [15:0] match_total;
  logic        final_report;

  // keyword registers as the predictor sees them
  logic [63:0] key_low_q;
  logic [63:0] key_high_q;
  logic [4:0]  key_len_q;

  // text scanning state of the predictor
  logic [4:0]  tok_len;
  logic        tok_equal;
  logic [15:0] line_q;
  logic [15:0] col_q;
  logic [15:0] start_q;
  logic [15:0] hits_q;

  report_t pending_reports[$];
  int      mismatch_count = 0;
  int      items_sent = 0;
  int      cycle_count = 0;
  int      gap_pct = 0;
  int      stall_pct = 0;
  int      holdoff_req_id = 0;
  int      holdoff_seen_id = 0;
  int      holdoff_left = 0;

  whole_word_search_line_column_top DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .push          (push),
    .full          (full),
    .text_byte     (text_byte),
    .end_of_text   (end_of_text),
    .empty         (empty),
    .pop           (pop),
    .report_kind   (report_kind),
    .line_number   (line_number),
    .column_number (column_number),
    .match_total   (match_total),
    .final_report  (final_report)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("whole_word_search_line_column_top test failed");
    $finish;
  end

  task automatic log_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  function automatic logic [15:0] bump_saturating(input logic [15:0] v);
    return (v == SAT16) ? v : v + 16'd1;
  endfunction

  function automatic logic is_delimiter(input logic [7:0] b);
    return b == CH_SPACE || b == CH_NEWLINE || b == CH_PERIOD || b == CH_COMMA;
  endfunction

  function automatic logic [7:0] key_char(input logic [4:0] pos);
    if (pos < 5'd8) begin
      return key_low_q[8*pos +: 8];
    end
    return key_high_q[8*(pos - 5'd8) +: 8];
  endfunction

  function automatic void clear_text();
    tok_len   = '0;
    tok_equal = 1'b1;
    line_q    = 16'd1;
    col_q     = '0;
    start_q   = '0;
    hits_q    = '0;
  endfunction

  function automatic void expect_report(input logic kind, input logic [15:0] line,
                                        input logic [15:0] column, input logic last);
    report_t r;
    r.kind   = kind;
    r.line   = line;
    r.column = column;
    r.total  = hits_q;
    r.last   = last;
    pending_reports.push_back(r);
  endfunction

  // closes the open token, true on a whole-word hit
  function automatic logic end_token();
    logic hit;
    hit = tok_len != 5'd0 && tok_equal && key_len_q >= 5'd1 &&
          key_len_q <= 5'(MAX_KEY) && tok_len == key_len_q;
    if (hit) hits_q = bump_saturating(hits_q);
    tok_len   = '0;
    tok_equal = 1'b1;
    return hit;
  endfunction

  // predicts the reports caused by one accepted byte
  task automatic scan_byte(input logic [7:0] b, input logic eot);
    logic [15:0] line_at;
    logic [15:0] start_at;
    if (is_delimiter(b)) begin
      line_at  = line_q;
      start_at = start_q;
      if (end_token()) expect_report(REPORT_MATCH, line_at, start_at, 1'b0);
      if (b == CH_NEWLINE) begin
        line_q = bump_saturating(line_q);
        col_q  = '0;
      end else begin
        col_q = bump_saturating(col_q);
      end
    end else begin
      if (tok_len == 5'd0) start_q = col_q;
      if (tok_len < key_len_q && tok_len < 5'(MAX_KEY)) begin
        if (key_char(tok_len) != b) tok_equal = 1'b0;
      end else begin
        tok_equal = 1'b0;
      end
      if (tok_len < 5'(MAX_KEY + 1)) tok_len = tok_len + 5'd1;
      col_q = bump_saturating(col_q);
      if (eot && end_token()) expect_report(REPORT_MATCH, line_q, start_q, 1'b0);
    end
    if (eot) begin
      expect_report(REPORT_COUNT, 16'd0, 16'd0, 1'b1);
      clear_text();
    end
  endtask

  // offers one byte, with a random run of idle cycles before it
  task automatic send_byte(input logic [7:0] b, input logic eot);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
    push        <= 1'b1;
    text_byte   <= b;
    end_of_text <= eot;
    do @(posedge clk); while (full);
    items_sent++;
    scan_byte(b, eot);
  endtask

  task automatic send_text(input string s, input logic close_text);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i], close_text && i == s.len() - 1);
  endtask

  // stop offering and wait until every expected report has come out
  task automatic drain_results();
    if (push) push <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one register transaction; cfg_valid stays high for the next one
  task automatic write_register(input logic [1:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_KEY_LOW:    key_low_q = value;
      CFG_KEY_HIGH:   key_high_q = value;
      CFG_KEY_LENGTH: key_len_q = value[4:0];
      default: ;
    endcase
  endtask

  task automatic set_keyword(input logic [63:0] low, input logic [63:0] high,
                             input logic [63:0] len);
    write_register(CFG_KEY_LOW, low);
    write_register(CFG_KEY_HIGH, high);
    write_register(CFG_KEY_LENGTH, len);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] rand_token_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (is_delimiter(b));
    return b;
  endfunction

  function automatic logic [7:0] rand_delimiter();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_NEWLINE;
      2: return CH_PERIOD;
      default: return CH_COMMA;
    endcase
  endfunction

  function automatic logic [63:0] rand_key_word();
    logic [63:0] w;
    int i;
    for (i = 0; i < 8; i++) w[8*i +: 8] = rand_token_byte();
    return w;
  endfunction

  // words built around the keyword, with noise, ending in closed texts
  task automatic send_word_mix(input int budget);
    logic [7:0] word[$];
    int base, klen, kind, n, i, p;
    logic close_text;
    base = items_sent;
    klen = (key_len_q >= 5'd1 && key_len_q <= 5'(MAX_KEY)) ? int'(key_len_q) : 3;
    while (items_sent - base < budget) begin
      word.delete();
      kind = $urandom_range(0, 99);
      if (kind < 74) begin
        // keyword, prefix, keyword plus tail, or keyword with one bit flipped
        n = (kind >= 40 && kind < 52) ? $urandom_range(1, klen) : klen;
        for (i = 0; i < n; i++) word.push_back(key_char(5'(i)));
        if (kind >= 52 && kind < 64) begin
          repeat ($urandom_range(1, 3)) word.push_back(rand_token_byte());
        end
        if (kind >= 64) begin
          p = $urandom_range(0, n - 1);
          word[p] = word[p] ^ (8'h01 << $urandom_range(0, 7));
        end
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 20)) word.push_back(rand_token_byte());
      end else begin
        repeat ($urandom_range(1, 4)) word.push_back(8'($urandom_range(0, 255)));
      end
      close_text = ($urandom_range(0, 9) == 0);
      if (!(close_text && $urandom_range(0, 1) == 1)) begin
        n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2);
        repeat (n) word.push_back(rand_delimiter());
      end
      for (i = 0; i < word.size(); i++) begin
        send_byte(word[i], close_text && i == word.size() - 1);
      end
    end
    send_byte(rand_delimiter(), 1'b1);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (holdoff_req_id != holdoff_seen_id) begin
      holdoff_seen_id <= holdoff_req_id;
      holdoff_left    <= HOLDOFF_LEN;
      pop             <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      pop          <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // compare each accepted result transaction with the oldest expectation
  always @(posedge clk) begin
    report_t want;
    if (!rst && pop && !empty) begin
      if (pending_reports.size() == 0) begin
        log_mismatch($sformatf("unexpected report kind %0d line %0d col %0d total %0d last %0d",
                               report_kind, line_number, column_number, match_total,
                               final_report));
      end else begin
        want = pending_reports.pop_front();
        if (report_kind !== want.kind || line_number !== want.line ||
            column_number !== want.column || match_total !== want.total ||
            final_report !== want.last) begin
          log_mismatch($sformatf({"kind %0d/%0d line %0d/%0d col %0d/%0d total %0d/%0d ",
                                  "last %0d/%0d (got/expected)"},
                                 report_kind, want.kind, line_number, want.line,
                                 column_number, want.column, match_total, want.total,
                                 final_report, want.last));
        end
      end
    end
  end

  // reset keyword is one zero byte: zero byte tokens, end on a delimiter
  task automatic test_reset_keyword();
    send_byte(8'h00, 1'b0);
    send_byte(CH_SPACE, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(CH_SPACE, 1'b1);
    drain_results();
  endtask

  // every delimiter, empty tokens, prefix, long token, match on the final byte
  task automatic test_delimiters_and_tokens();
    set_keyword(64'h0000_0000_0000_6261, 64'h0, 64'd2);
    send_text("ab, a.abc\n,ab", 1'b1);
    drain_results();
  endtask

  // key length of zero and above the maximum never matches
  task automatic test_length_out_of_range();
    set_keyword(64'h0, 64'h0, 64'd0);
    send_byte(8'h00, 1'b1);
    drain_results();
    set_keyword(64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    drain_results();
  endtask

  // receiver holds off while the sender keeps going, then the sender waits
  task automatic test_backpressure();
    logic [7:0] c0, c1;
    int i;
    c0 = rand_token_byte();
    c1 = rand_token_byte();
    drain_results();
    set_keyword({48'h0, c1, c0}, rand_key_word(), 64'd2);
    gap_pct   = 0;
    stall_pct = 0;
    holdoff_req_id <= holdoff_req_id + 1;
    for (i = 0; i < 20; i++) begin
      send_byte(c0, 1'b0);
      send_byte(c1, 1'b0);
      send_byte(CH_SPACE, 1'b0);
    end
    drain_results();
    send_byte(c0, 1'b0);
    send_byte(c1, 1'b1);
    drain_results();
  endtask

  // random texts under four idling settings and several keywords
  task automatic test_random_texts();
    int gaps[4]   = '{0, 55, 0, 29};
    int stalls[4] = '{0, 0, 55, 29};
    int ph;
    for (ph = 0; ph < 4; ph++) begin
      drain_results();
      case (ph)
        0: set_keyword({64{1'b1}}, {64{1'b1}}, 64'd16);
        1: set_keyword(rand_key_word(), rand_key_word(), 64'($urandom_range(1, 16)));
        2: set_keyword(rand_key_word(), rand_key_word(), 64'd1);
        default: set_keyword(rand_key_word(), rand_key_word(), 64'($urandom_range(2, 15)));
      endcase
      gap_pct   = gaps[ph];
      stall_pct = stalls[ph];
      send_word_mix(100);
    end
    drain_results();
    gap_pct   = 0;
    stall_pct = 0;
  endtask

  initial begin
    rst         = 1'b1;
    push        = 1'b0;
    text_byte   = '0;
    end_of_text = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    key_low_q   = '0;
    key_high_q  = '0;
    key_len_q   = 5'd1;
    clear_text();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_reset_keyword();
    test_delimiters_and_tokens();
    test_length_out_of_range();
    test_backpressure();
    test_random_texts();

    drain_results();
    if (mismatch_count == 0) begin
      $display("whole_word_search_line_column_top test passed");
    end else begin
      $display("whole_word_search_line_column_top test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/wws_pkg.sv
sv/wws_front.sv
sv/wws_queue.sv
sv/wws_back.sv
sv/whole_word_search_line_column_top.sv
bench/tb_whole_word_search_line_column_top.sv
